// ===== rtl/wmad_pkg.sv =====
// Shared types and constants of the window mean absolute deviation filter.
// No dependencies.
package wmad_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 3;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 24;
  localparam int DEV_W     = 16;
  localparam int COORD_W   = 10;
  localparam int OUT_W     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2,
    CFG_COLOR_MODE    = 2'd3
  } cfg_idx_t;

  localparam logic [10:0]      RST_WIDTH    = 11'd640;
  localparam logic [10:0]      RST_HEIGHT   = 11'd480;
  localparam logic [1:0]       RST_RADIUS   = 2'd1;
  localparam logic             RST_COLOR    = 1'b1;
  localparam logic [DEV_W-1:0] BORDER_VALUE = 16'hFF00;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_dev;
    logic latch_pos;
    logic walk_start;
    logic rd_sum;
    logic rd_dev;
    logic latch_dev;
    logic set_border;
    logic load_out;
  } wmad_cmd_t;

  typedef struct packed {
    logic has_out;
    logic in_window;
    logic div_busy;
    logic div_done;
    logic walk_last;
    logic out_free;
  } wmad_stat_t;

endpackage

// ===== rtl/window_mean_abs_deviation_filter.sv =====
// Top level of the window mean absolute deviation filter.
// Depends on wmad_pkg, wmad_ctrl, wmad_datapath (which holds wmad_div).
//
//  channel | signals                         | content
//  s       | s_tvalid s_tready s_tdata s_tuser | pixel in, tuser = pad tick
//  m       | m_tvalid m_tready m_tdata m_tlast | deviation result, tlast = frame end
//  cfg     | cfg_we cfg_index cfg_data         | register write, no read-back
//
// An item with no result is only accepted. A border result needs the position divide; an
// inside result also needs two passes over the window and the scaling divide. The
// one-bit-per-cycle divider (width D, 29 at default size) and the single line store read
// port set the time per result. Reset is synchronous.
// A stalled output holds the next result in the controller until taken.
module window_mean_abs_deviation_filter #(
  parameter int MAX_WIDTH  = wmad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmad_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = wmad_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [wmad_pkg::PIX_W-1:0]     s_tdata,   // red, green, blue
  input  logic                           s_tuser,   // pad: store a zero pixel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [wmad_pkg::OUT_W-1:0]     m_tdata,   // deviation, column, row, zero fill
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [wmad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wmad_pkg::CFG_W-1:0]     cfg_data
);
  import wmad_pkg::*;

  wmad_cmd_t  cmd;
  wmad_stat_t st;

  wmad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_ready  (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  wmad_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/wmad_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
module wmad_div #(
  parameter int NW = 29,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] den_q;
  logic [DW:0]   r_shift;
  logic [DW:0]   r_try;

  always_comb begin
    r_shift = {rem, quot[NW-1]};
    r_try   = r_shift - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NW);
        quot  <= num;
        rem   <= '0;
        den_q <= den;
      end else if (busy) begin
        if (r_shift >= {1'b0, den_q}) begin
          rem  <= r_try[DW-1:0];
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem  <= r_shift[DW-1:0];
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without work");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

// ===== rtl/wmad_datapath.sv =====
// Datapath: config registers, position counters, line store, window walker,
// accumulators, shared divider and output register. Uses wmad_pkg, wmad_div.
module wmad_datapath #(
  parameter int MAX_WIDTH  = wmad_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wmad_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = wmad_pkg::MAX_RADIUS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wmad_pkg::wmad_cmd_t                 cmd,
  output wmad_pkg::wmad_stat_t                st,
  input  logic [wmad_pkg::PIX_W-1:0]          s_tdata,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wmad_pkg::OUT_W-1:0]          m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_we,
  input  logic [wmad_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wmad_pkg::CFG_W-1:0]          cfg_data
);
  import wmad_pkg::*;

  localparam int DEPTH    = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int LAG_MAX  = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
  localparam int PW       = $clog2(MAX_WIDTH * MAX_HEIGHT + LAG_MAX + 1);
  localparam int SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int SDW      = $clog2(SIDE_MAX + 1);
  localparam int N_MAX    = SIDE_MAX * SIDE_MAX;
  localparam int NNW      = $clog2(N_MAX + 1);
  localparam int SW       = $clog2(N_MAX * 255 + 1);
  localparam int TW       = $clog2(3 * N_MAX * N_MAX * 255 + 1);
  localparam int VW       = $clog2(3 * N_MAX * N_MAX + 1);
  localparam int DNW      = (TW + 8 > PW) ? TW + 8 : PW;
  localparam int DDW      = (VW > WW) ? VW : WW;

  logic [CFG_W-1:0] cfg_w, cfg_h;
  logic [1:0]       cfg_rad;
  logic             cfg_color;

  logic [31:0] w32, h32, r32, side32, tot32, lag32;
  logic [WW-1:0]  w_eff;
  logic [SDW-1:0] side;
  logic [NNW-1:0] n_win;
  logic [PW-1:0]  total, lag, endp;

  logic [PW-1:0] p, p_eff, q;
  logic [PW:0]   p_inc;
  logic [AW-1:0] wp, wp_eff, wstart;
  logic [31:0]   wp_inc, ws32;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata;
  logic             rd_sum_d, rd_dev_d;

  logic [SDW-1:0] wi, wj;
  logic [AW-1:0]  row_base, waddr;
  logic [31:0]    nb32, na32;

  logic [SW-1:0]  s0, s1, s2;
  logic [TW-1:0]  tot;
  logic [SW-1:0]  nv0, nv1, nv2, d0, d1, d2;
  logic [31:0]    nn32, dv32;

  logic           div_busy, div_done;
  logic [DNW-1:0] div_num, div_quot;
  logic [DDW-1:0] div_den, div_rem;

  logic [WW-1:0]    col;
  logic [HW-1:0]    row;
  logic [31:0]      col32, row32;
  logic [DEV_W-1:0] res_dev;

  // frame geometry
  always_comb begin
    w32 = (cfg_w == '0) ? 32'd1 : ((32'(cfg_w) > MAX_WIDTH) ? 32'(MAX_WIDTH) : 32'(cfg_w));
    h32 = (cfg_h == '0) ? 32'd1 :
          ((32'(cfg_h) > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : 32'(cfg_h));
    r32 = (32'(cfg_rad) > MAX_RADIUS) ? 32'(MAX_RADIUS) : 32'(cfg_rad);
    side32 = 2 * r32 + 32'd1;
    tot32  = w32 * h32;
    lag32  = r32 * w32 + r32;
    w_eff  = WW'(w32);
    side   = SDW'(side32);
    n_win  = NNW'(side32 * side32);
    total  = PW'(tot32);
    lag    = PW'(lag32);
    endp   = PW'(tot32 + lag32);
  end

  // positions
  always_comb begin
    p_eff  = (p >= endp) ? '0 : p;
    wp_eff = (p >= endp) ? '0 : wp;
    p_inc  = {1'b0, p_eff} + (PW+1)'(1);
    wp_inc = 32'(wp_eff) + 32'd1;
    if (wp_inc >= DEPTH) wp_inc = wp_inc - DEPTH;
    ws32 = 32'(wp_eff) + DEPTH - 2 * 32'(lag);
    if (ws32 >= DEPTH) ws32 = ws32 - DEPTH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w     <= RST_WIDTH;
      cfg_h     <= RST_HEIGHT;
      cfg_rad   <= RST_RADIUS;
      cfg_color <= RST_COLOR;
      p         <= '0;
      wp        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FRAME_WIDTH:   cfg_w     <= cfg_data;
          CFG_FRAME_HEIGHT:  cfg_h     <= cfg_data;
          CFG_WINDOW_RADIUS: cfg_rad   <= cfg_data[1:0];
          CFG_COLOR_MODE:    cfg_color <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (p_inc >= {1'b0, endp}) begin
          p  <= '0;
          wp <= '0;
        end else begin
          p  <= p_inc[PW-1:0];
          wp <= AW'(wp_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      q      <= p_eff - lag;
      wstart <= AW'(ws32);
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.accept && p_eff < total) begin
      mem[wp_eff] <= s_tuser ? '0 : s_tdata;
    end
    rdata <= mem[waddr];
  end

  // window walker
  always_comb begin
    nb32 = 32'(row_base) + 32'(w_eff);
    if (nb32 >= DEPTH) nb32 = nb32 - DEPTH;
    na32 = 32'(waddr) + 32'd1;
    if (na32 >= DEPTH) na32 = na32 - DEPTH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sum_d <= 1'b0;
      rd_dev_d <= 1'b0;
    end else begin
      rd_sum_d <= cmd.rd_sum;
      rd_dev_d <= cmd.rd_dev;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      wi       <= '0;
      wj       <= '0;
      row_base <= wstart;
      waddr    <= wstart;
    end else if (cmd.rd_sum || cmd.rd_dev) begin
      if (wi == side - SDW'(1)) begin
        wi       <= '0;
        wj       <= wj + SDW'(1);
        row_base <= AW'(nb32);
        waddr    <= AW'(nb32);
      end else begin
        wi    <= wi + SDW'(1);
        waddr <= AW'(na32);
      end
    end
  end

  // accumulators
  always_comb begin
    nv0 = SW'(n_win) * SW'(rdata[7:0]);
    nv1 = SW'(n_win) * SW'(rdata[15:8]);
    nv2 = SW'(n_win) * SW'(rdata[23:16]);
    d0  = (s0 >= nv0) ? s0 - nv0 : nv0 - s0;
    d1  = (s1 >= nv1) ? s1 - nv1 : nv1 - s1;
    d2  = (s2 >= nv2) ? s2 - nv2 : nv2 - s2;
    nn32 = 32'(n_win) * 32'(n_win);
    dv32 = cfg_color ? nn32 * 32'd3 : nn32;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_pos) begin
      s0  <= '0;
      s1  <= '0;
      s2  <= '0;
      tot <= '0;
    end else begin
      if (rd_sum_d) begin
        s0 <= s0 + SW'(rdata[7:0]);
        s1 <= s1 + SW'(rdata[15:8]);
        s2 <= s2 + SW'(rdata[23:16]);
      end
      if (rd_dev_d) begin
        tot <= tot + TW'(d0) + (cfg_color ? TW'(d1) + TW'(d2) : '0);
      end
    end
  end

  // shared divider: q / width, then deviation scaling
  assign div_num = cmd.div_sel_dev ? DNW'({tot, 8'd0}) : DNW'(q);
  assign div_den = cmd.div_sel_dev ? DDW'(dv32) : DDW'(w_eff);

  wmad_div #(.NW(DNW), .DW(DDW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_pos) begin
      col <= WW'(div_rem);
      row <= HW'(div_quot);
    end
    if (cmd.latch_dev) begin
      res_dev <= div_quot[DEV_W-1:0];
    end else if (cmd.set_border) begin
      res_dev <= BORDER_VALUE;
    end
  end

  assign col32 = 32'(col);
  assign row32 = 32'(row);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {4'd0, row32[COORD_W-1:0], col32[COORD_W-1:0], res_dev};
      m_tlast <= (q == total - PW'(1));
    end
  end

  always_comb begin
    st.has_out   = (p_eff >= lag);
    st.in_window = (col32 >= r32) && (col32 + r32 < w32) &&
                   (row32 >= r32) && (row32 + r32 < h32);
    st.div_busy  = div_busy;
    st.div_done  = div_done;
    st.walk_last = (wi == side - SDW'(1)) && (wj == side - SDW'(1));
    st.out_free  = !m_tvalid || m_tready;
  end

endmodule

// ===== rtl/wmad_ctrl.sv =====
// Controller FSM: sequences position divide, window passes, scaling divide
// and output load. Uses wmad_pkg.
module wmad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_ready,
  input  wmad_pkg::wmad_stat_t st,
  output wmad_pkg::wmad_cmd_t  cmd
);
  import wmad_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_POSW, S_CHK, S_SUM, S_SUMW,
    S_DEV, S_DEVW, S_DIVD, S_DIVDW, S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_ready    = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid && st.has_out) state_next = S_POS;
      end
      S_POS: begin
        cmd.div_start = 1'b1;
        state_next    = S_POSW;
      end
      S_POSW: begin
        if (st.div_done) begin
          cmd.latch_pos = 1'b1;
          state_next    = S_CHK;
        end
      end
      S_CHK: begin
        if (st.in_window) begin
          cmd.walk_start = 1'b1;
          state_next     = S_SUM;
        end else begin
          cmd.set_border = 1'b1;
          state_next     = S_DONE;
        end
      end
      S_SUM: begin
        cmd.rd_sum = 1'b1;
        if (st.walk_last) state_next = S_SUMW;
      end
      S_SUMW: begin
        cmd.walk_start = 1'b1;
        state_next     = S_DEV;
      end
      S_DEV: begin
        cmd.rd_dev = 1'b1;
        if (st.walk_last) state_next = S_DEVW;
      end
      S_DEVW: state_next = S_DIVD;
      S_DIVD: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_dev = 1'b1;
        state_next      = S_DIVDW;
      end
      S_DIVDW: begin
        cmd.div_sel_dev = 1'b1;
        if (st.div_done) begin
          cmd.latch_dev = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_accept_div: assert property (@(posedge clk) disable iff (rst)
    st.div_busy |-> !cmd.accept)
    else $error("transaction accepted while divider busy");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> st.out_free)
    else $error("output register overwritten");
  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> s_ready)
    else $error("transaction accepted while not ready");

endmodule

// ===== tb/testbench.sv =====
// Testbench for window_mean_abs_deviation_filter: random and patterned frames of pixels are streamed in,
// and a scoreboard predicts and checks each deviation result, field by field.
// Depends on wmad_pkg and the filter RTL.
`timescale 1ns / 1ps

module testbench;
  import wmad_pkg::*;

  localparam int STORE_N = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [DEV_W-1:0]   deviation;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } dev_result_t;

  class deviation_scoreboard;
    logic [PIX_W-1:0] line_store [STORE_N];
    int unsigned pos_count;
    int unsigned width_reg, height_reg, radius_reg, color_reg;
    dev_result_t expected_q[$];
    int errors;

    function new();
      pos_count = 0;
      width_reg = 640;
      height_reg = 480;
      radius_reg = 1;
      color_reg = 1;
      errors = 0;
      foreach (line_store[k]) line_store[k] = '0;
    endfunction

    function void write_reg(cfg_idx_t idx, int unsigned val);
      case (idx)
        CFG_FRAME_WIDTH:   width_reg = val & 11'h7FF;
        CFG_FRAME_HEIGHT:  height_reg = val & 11'h7FF;
        CFG_WINDOW_RADIUS: radius_reg = val & 2'h3;
        CFG_COLOR_MODE:    color_reg = val & 1'b1;
        default: ;
      endcase
    endfunction

    function int unsigned window_mad(int unsigned r, int unsigned c, int unsigned w,
                                     int unsigned rad, int unsigned nch);
      longint unsigned side, n, total, s, nv, v;
      int unsigned p;
      side = 2 * rad + 1;
      n = side * side;
      total = 0;
      for (int ch = 0; ch < nch; ch++) begin
        s = 0;
        for (int j = 0; j < side; j++)
          for (int i = 0; i < side; i++) begin
            p = (r - rad + j) * w + (c - rad + i);
            s += (line_store[p % STORE_N] >> (8 * ch)) & 8'hFF;
          end
        for (int j = 0; j < side; j++)
          for (int i = 0; i < side; i++) begin
            p = (r - rad + j) * w + (c - rad + i);
            v = (line_store[p % STORE_N] >> (8 * ch)) & 8'hFF;
            nv = n * v;
            total += (s >= nv) ? (s - nv) : (nv - s);
          end
      end
      return 32'((total * 256) / (n * n * nch));
    endfunction

    function void note_pixel(logic pad, logic [PIX_W-1:0] pix);
      int unsigned w, h, rad, total, lag, fin, p, q, r, c;
      dev_result_t e;
      w = width_reg < 1 ? 1 : (width_reg > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : width_reg);
      h = height_reg < 1 ? 1 : (height_reg > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : height_reg);
      rad = radius_reg > MAX_RADIUS_DEF ? MAX_RADIUS_DEF : radius_reg;
      total = w * h;
      lag = rad * w + rad;
      fin = total + lag;
      p = pos_count;
      if (p >= fin) p = 0;
      if (p < total) line_store[p % STORE_N] = pad ? '0 : pix;
      if (p >= lag) begin
        q = p - lag;
        r = q / w;
        c = q % w;
        if (c >= rad && c + rad < w && r >= rad && r + rad < h)
          e.deviation = DEV_W'(window_mad(r, c, w, rad, color_reg ? 3 : 1));
        else
          e.deviation = BORDER_VALUE;
        e.column = c[COORD_W-1:0];
        e.row = r[COORD_W-1:0];
        e.frame_end = (q == total - 1);
        expected_q.insert(expected_q.size(), e);
      end
      pos_count = (p + 1 >= fin) ? 0 : p + 1;
    endfunction

    function void check_result(dev_result_t got);
      dev_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.deviation !== e.deviation) begin
        $display("%0t: deviation expected %h actual %h", $time, e.deviation, got.deviation);
        errors++;
      end
      if (got.column !== e.column) begin
        $display("%0t: column expected %0d actual %0d", $time, e.column, got.column);
        errors++;
      end
      if (got.row !== e.row) begin
        $display("%0t: row expected %0d actual %0d", $time, e.row, got.row);
        errors++;
      end
      if (got.frame_end !== e.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, got.frame_end);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [PIX_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  deviation_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int sent_items = 0;
  int frame_no = 0;

  window_mean_abs_deviation_filter u_top (.*);

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result('{m_tdata[15:0], m_tdata[25:16], m_tdata[35:26], m_tlast});
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_pixel(logic pad, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = pad;
    s_tdata = {blue, green, red};
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(pad, s_tdata);
    sent_items++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain_results();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, int unsigned val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one full frame plus its flush; pattern 0 random, 1 checkerboard extremes
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned rad, int unsigned color,
                           int pattern, int pad_pct);
    int unsigned wc, hc, steps, n_pix;
    drain_results();
    case (frame_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
    frame_no++;
    write_cfg(CFG_FRAME_WIDTH, w);
    write_cfg(CFG_FRAME_HEIGHT, h);
    write_cfg(CFG_WINDOW_RADIUS, rad);
    write_cfg(CFG_COLOR_MODE, color);
    wc = (w & 11'h7FF) < 1 ? 1 : ((w & 11'h7FF) > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : (w & 11'h7FF));
    hc = (h & 11'h7FF) < 1 ? 1 : ((h & 11'h7FF) > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : (h & 11'h7FF));
    n_pix = wc * hc;
    steps = n_pix + rad * wc + rad;
    for (int unsigned k = 0; k < steps; k++) begin
      if (frame_no == 1 && k == n_pix / 2)
        while (sb.expected_q.size() != 0) @(negedge clk);
      if (pattern == 1)
        send_pixel(k == 5, ((k + k / wc) % 2) ? 8'hFF : 8'h00, (k % 3) ? 8'hFF : 8'h00,
                   (k % 2) ? 8'h00 : 8'hFF);
      else if (k < n_pix)
        send_pixel($urandom_range(99) < pad_pct, rand_chan(), rand_chan(), rand_chan());
      else
        send_pixel($urandom_range(1) == 1, rand_chan(), rand_chan(), rand_chan());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_frame(4, 4, 1, 1, 1, 0);
    run_frame(5, 4, 1, 0, 1, 0);
    run_frame(0, 0, 0, 1, 0, 0);
    run_frame(7, 7, 3, 1, 0, 10);
    run_frame(7, 7, 3, 0, 0, 10);
    run_frame(0, 3, 1, 1, 0, 5);
    run_frame(3, 0, 0, 0, 0, 5);
    run_frame(6, 5, 2, 1, 0, 10);

    while (sent_items < 1000)
      run_frame($urandom_range(1, 9), $urandom_range(1, 8), $urandom_range(3),
                $urandom_range(1), 0, $urandom_range(3) == 0 ? 15 : 0);

    drain_results();
    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
